[src/brs_pkg.sv]
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants for the bounded record stack
// Command codes, status codes, widths and the memory word layout.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int Depth    = 16;
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW   = $clog2(Depth + 1);
  localparam int CodeW    = 16;
  localparam int AgeW     = 8;
  localparam int WordW    = CodeW + AgeW;
  localparam int PosW     = 4;
  localparam int EcntW    = 5;
  localparam int MaxRes   = 16;
  localparam int SumW     = AgeW + CountW + 8;
  localparam int MeanW    = 16;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_PUSH  = 3'd1,
    CMD_POP   = 3'd2,
    CMD_DUMPT = 3'd3,
    CMD_DUMPB = 3'd4,
    CMD_FIND  = 3'd5,
    CMD_SORT  = 3'd6,
    CMD_STATS = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOTFD = 2'd3
  } status_t;

  // Result beat registered by the sequencer and driven onto the result ports.
  typedef struct packed {
    logic               strobe;
    status_t            status;
    logic [CodeW-1:0]   code;
    logic [AgeW-1:0]    age;
    logic [PosW-1:0]    pos;
    logic [EcntW-1:0]   ecnt;
    logic [AgeW-1:0]    amax;
    logic [AgeW-1:0]    amin;
    logic [MeanW-1:0]   mean;
    logic               last;
  } beat_t;

endpackage

[src/brs_ram.sv]
// ----------------------------------------------------------------------------
// brs_ram: generic single-port-write, one-read RAM
// Registered read.
// ----------------------------------------------------------------------------
module brs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/brs_div.sv]
// ----------------------------------------------------------------------------
// brs_div: restoring divider for the stats mean
// One quotient bit per cycle; quotient truncated to the mean width.
// ----------------------------------------------------------------------------
module brs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [brs_pkg::SumW-1:0]   dividend,
  input  logic [brs_pkg::CountW-1:0] divisor,
  output logic                       done,
  output logic [brs_pkg::MeanW-1:0]  quot
);
  import brs_pkg::*;

  localparam int StepW = $clog2(SumW + 1);

  logic [SumW-1:0]   num;
  logic [SumW-1:0]   q;
  logic [CountW:0]   rem;
  logic [CountW-1:0] den;
  logic [StepW-1:0]  steps;
  logic              run;
  logic [CountW:0]   trial;
  logic [CountW:0]   shifted;

  assign shifted = {rem[CountW-1:0], num[SumW-1]};
  assign trial   = shifted - {1'b0, den};
  assign quot    = q[MeanW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        num   <= dividend;
        den   <= divisor;
        rem   <= '0;
        q     <= '0;
        steps <= StepW'(SumW);
      end else if (run) begin
        num <= num << 1;
        if (!trial[CountW]) begin
          rem <= trial;
          q   <= {q[SumW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[SumW-2:0], 1'b0};
        end
        steps <= steps - StepW'(1);
        if (steps == StepW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/brs_ctrl.sv]
// ----------------------------------------------------------------------------
// brs_ctrl: command sequencer
// Walks the record memory one entry per step and forms result beats.
// ----------------------------------------------------------------------------
module brs_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [2:0]                 command,
  input  logic [brs_pkg::CodeW-1:0]  record_code,
  input  logic [brs_pkg::AgeW-1:0]   record_age,
  output logic                       busy,
  output logic                       we,
  output logic [brs_pkg::AddrW-1:0]  waddr,
  output logic [brs_pkg::WordW-1:0]  wdata,
  output logic [brs_pkg::AddrW-1:0]  raddr,
  input  logic [brs_pkg::WordW-1:0]  rdata,
  output logic                       div_go,
  output logic [brs_pkg::SumW-1:0]   div_num,
  output logic [brs_pkg::CountW-1:0] div_den,
  input  logic                       div_done,
  input  logic [brs_pkg::MeanW-1:0]  div_quot,
  output brs_pkg::beat_t             beat
);
  import brs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_POP   = 10'b0000000010,
    S_DUMP  = 10'b0000000100,
    S_FIND  = 10'b0000001000,
    S_SRDI  = 10'b0000010000,
    S_SRDJ  = 10'b0000100000,
    S_SCMP  = 10'b0001000000,
    S_SWB   = 10'b0010000000,
    S_STAT  = 10'b0100000000,
    S_DIV   = 10'b1000000000
  } state_t;

  state_t            state;
  cmd_t              cmd;
  logic [CountW-1:0] top;
  logic [CountW-1:0] cnt;      // walk counter
  logic [CountW-1:0] ia;       // sort outer index
  logic [CountW-1:0] ja;       // sort inner index
  logic [CodeW-1:0]  key;
  logic [WordW-1:0]  wi;       // entry i held during the sort
  logic [AgeW-1:0]   amax;
  logic [AgeW-1:0]   amin;
  logic [SumW-1:0]   asum;
  logic              rd_ok;    // walk read address issued this cycle
  logic              rd_vld;   // rdata holds the walk entry ridx
  logic [AddrW-1:0]  ridx;     // index whose data arrives now
  logic [CountW-1:0] nres;

  logic [CodeW-1:0]  rcode;
  logic [AgeW-1:0]   rage;
  assign rcode = rdata[WordW-1:AgeW];
  assign rage  = rdata[AgeW-1:0];
  assign busy  = (state != S_IDLE);
  assign div_num = asum << 8;
  assign div_den = top;

  function automatic beat_t mk(status_t st, logic [CountW-1:0] tc);
    beat_t b;
    b        = '0;
    b.strobe = 1'b1;
    b.status = st;
    b.ecnt   = EcntW'(tc);
    b.last   = 1'b1;
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      top    <= '0;
      we     <= 1'b0;
      div_go <= 1'b0;
      beat   <= '0;
      rd_ok  <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      we     <= 1'b0;
      div_go <= 1'b0;
      beat   <= '0;
      rd_ok  <= 1'b0;
      rd_vld <= rd_ok;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= cmd_t'(command);
            key <= record_code;
            case (cmd_t'(command))
              CMD_CLEAR: begin
                top  <= '0;
                beat <= mk(ST_OK, '0);
              end
              CMD_PUSH: begin
                if (top == CountW'(Depth)) begin
                  beat <= mk(ST_FULL, top);
                end else begin
                  we    <= 1'b1;
                  waddr <= top[AddrW-1:0];
                  wdata <= {record_code, record_age};
                  top   <= top + CountW'(1);
                  beat  <= mk(ST_OK, top + CountW'(1));
                end
              end
              CMD_POP: begin
                if (top == '0) begin
                  beat <= mk(ST_EMPTY, top);
                end else begin
                  raddr <= AddrW'(top - CountW'(1));
                  top   <= top - CountW'(1);
                  rd_ok <= 1'b1;
                  state <= S_POP;
                end
              end
              CMD_DUMPT, CMD_DUMPB: begin
                if (top == '0) begin
                  beat <= mk(ST_EMPTY, top);
                end else begin
                  nres  <= (top < CountW'(MaxRes)) ? top : CountW'(MaxRes);
                  cnt   <= '0;
                  raddr <= (cmd_t'(command) == CMD_DUMPT) ?
                           AddrW'(top - CountW'(1)) : '0;
                  ridx  <= (cmd_t'(command) == CMD_DUMPT) ?
                           AddrW'(top - CountW'(1)) : '0;
                  rd_ok <= 1'b1;
                  state <= S_DUMP;
                end
              end
              CMD_FIND: begin
                if (top == '0) begin
                  beat <= mk(ST_NOTFD, top);
                end else begin
                  cnt   <= top;
                  raddr <= AddrW'(top - CountW'(1));
                  ridx  <= AddrW'(top - CountW'(1));
                  rd_ok <= 1'b1;
                  state <= S_FIND;
                end
              end
              CMD_SORT: begin
                if (top == '0) begin
                  beat <= mk(ST_EMPTY, top);
                end else if (top == CountW'(1)) begin
                  beat <= mk(ST_OK, top);
                end else begin
                  ia    <= '0;
                  raddr <= '0;
                  state <= S_SRDI;
                end
              end
              default: begin
                if (top == '0) begin
                  beat <= mk(ST_EMPTY, top);
                end else begin
                  cnt   <= '0;
                  raddr <= '0;
                  ridx  <= '0;
                  rd_ok <= 1'b1;
                  amax  <= '0;
                  amin  <= '1;
                  asum  <= '0;
                  state <= S_STAT;
                end
              end
            endcase
          end
        end
        S_POP: begin
          if (rd_vld) begin
            beat      <= mk(ST_OK, top);
            beat.code <= rcode;
            beat.age  <= rage;
            state     <= S_IDLE;
          end
        end
        S_DUMP: begin
          // rdata holds entry ridx; issue the next read unless this is the last beat
          if (rd_vld) begin
            beat      <= mk(ST_OK, top);
            beat.code <= rcode;
            beat.age  <= rage;
            beat.pos  <= PosW'(ridx);
            beat.last <= (cnt + CountW'(1) == nres);
            if (cnt + CountW'(1) == nres) begin
              state <= S_IDLE;
            end else begin
              cnt   <= cnt + CountW'(1);
              rd_ok <= 1'b1;
              if (cmd == CMD_DUMPT) begin
                raddr <= ridx - AddrW'(1);
                ridx  <= ridx - AddrW'(1);
              end else begin
                raddr <= ridx + AddrW'(1);
                ridx  <= ridx + AddrW'(1);
              end
            end
          end
        end
        S_FIND: begin
          if (rd_vld) begin
            if (rcode == key) begin
              beat      <= mk(ST_OK, top);
              beat.code <= rcode;
              beat.age  <= rage;
              beat.pos  <= PosW'(ridx);
              state     <= S_IDLE;
            end else if (cnt == CountW'(1)) begin
              beat  <= mk(ST_NOTFD, top);
              state <= S_IDLE;
            end else begin
              cnt   <= cnt - CountW'(1);
              raddr <= ridx - AddrW'(1);
              ridx  <= ridx - AddrW'(1);
              rd_ok <= 1'b1;
            end
          end
        end
        S_SRDI: begin
          // read of entry ia is in flight; start reading j = ia+1
          ja    <= ia + CountW'(1);
          raddr <= AddrW'(ia + CountW'(1));
          state <= S_SRDJ;
        end
        S_SRDJ: begin
          wi    <= rdata;
          state <= S_SCMP;
        end
        S_SCMP: begin
          // rdata holds entry ja; wi holds current entry ia
          if (wi[WordW-1:AgeW] > rcode) begin
            we    <= 1'b1;
            waddr <= AddrW'(ja);
            wdata <= wi;
            wi    <= rdata;
          end
          state <= S_SWB;
          if (ja + CountW'(1) != top) begin
            raddr <= AddrW'(ja + CountW'(1));
          end
        end
        S_SWB: begin
          if (ja + CountW'(1) != top) begin
            ja    <= ja + CountW'(1);
            state <= S_SCMP;
          end else begin
            // inner pass done: write back entry ia
            we    <= 1'b1;
            waddr <= AddrW'(ia);
            wdata <= wi;
            if (ia + CountW'(2) == top) begin
              beat  <= mk(ST_OK, top);
              state <= S_IDLE;
            end else begin
              ia    <= ia + CountW'(1);
              raddr <= AddrW'(ia + CountW'(1));
              state <= S_SRDI;
            end
          end
        end
        S_STAT: begin
          if (rd_vld) begin
            if (rage > amax) amax <= rage;
            if (rage < amin) amin <= rage;
            asum <= asum + SumW'(rage);
            if (cnt + CountW'(1) == top) begin
              state <= S_DIV;
              cnt   <= '0;
            end else begin
              cnt   <= cnt + CountW'(1);
              raddr <= ridx + AddrW'(1);
              ridx  <= ridx + AddrW'(1);
              rd_ok <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            div_go <= 1'b1;
            cnt    <= CountW'(1);
          end else if (div_done) begin
            beat      <= mk(ST_OK, top);
            beat.amax <= amax;
            beat.amin <= amin;
            beat.mean <= div_quot;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/bounded_record_stack_unit.sv]
// ----------------------------------------------------------------------------
// bounded_record_stack_unit: bounded stack of code/age records
// Push, pop, dump, search, exchange sort and age statistics over one RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Results come back
// as beats on the result ports, each shown for one cycle with strobe high;
// the receiver cannot stall, so capture every strobe. Clear and push need no
// walk; pop makes one read, dump and search read one entry per step (up to
// 16 beats for a dump), statistics make one pass over the RAM, then a
// bit-serial divide for the mean, and sort makes one exchange pass per outer
// index. Each step waits on the registered read of the record RAM, reached
// through a registered address, and statistics also wait on the serial
// divide. busy is high while such a walk runs and is low again in the cycle
// the final beat (last = 1) is shown.
module bounded_record_stack_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [2:0]   command,
  input  logic [15:0]  record_code,
  input  logic [7:0]   record_age,
  output logic         strobe,
  output logic [1:0]   status,
  output logic [15:0]  out_code,
  output logic [7:0]   out_age,
  output logic [3:0]   position,
  output logic [4:0]   entry_count,
  output logic [7:0]   age_max,
  output logic [7:0]   age_min,
  output logic [15:0]  age_mean_q8,
  output logic         last
);
  import brs_pkg::*;

  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [WordW-1:0]  wdata;
  logic [AddrW-1:0]  raddr;
  logic [WordW-1:0]  rdata;
  logic              div_go;
  logic [SumW-1:0]   div_num;
  logic [CountW-1:0] div_den;
  logic              div_done;
  logic [MeanW-1:0]  div_quot;
  beat_t             beat;
  logic              ctrl_busy;

  // Record store: code in the high bits, age in the low bits.
  brs_ram #(.Width(WordW), .Depth(Depth)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  brs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  brs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .command     (command),
    .record_code (record_code),
    .record_age  (record_age),
    .busy        (ctrl_busy),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr       (raddr),
    .rdata       (rdata),
    .div_go      (div_go),
    .div_num     (div_num),
    .div_den     (div_den),
    .div_done    (div_done),
    .div_quot    (div_quot),
    .beat        (beat)
  );

  // Hold off new commands while a walk runs; busy is low when its final beat is out.
  assign busy        = ctrl_busy;
  assign strobe      = beat.strobe;
  assign status      = beat.status;
  assign out_code    = beat.code;
  assign out_age     = beat.age;
  assign position    = beat.pos;
  assign entry_count = beat.ecnt;
  assign age_max     = beat.amax;
  assign age_min     = beat.amin;
  assign age_mean_q8 = beat.mean;
  assign last        = beat.last;

endmodule
